[rtl/tcch_pkg.sv]
package tcch_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int DIV_STEPS     = 17;
	localparam int FRONT_DEPTH   = (CORDIC_N > DIV_STEPS) ? CORDIC_N : DIV_STEPS;
	localparam int SH_W          = 5;
	localparam int AW            = 50;
	localparam int ZW            = 35;

	localparam logic signed [33:0] PI_Q30        = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30   = 34'sd1686629713;
	localparam logic signed [31:0] GAIN_Q30      = 32'sd652032874;
	localparam logic signed [15:0] HEADING_LIMIT = 16'sd25736;

	typedef enum logic [2:0] {
		REG_X_MIN       = 3'd0,
		REG_X_MAX       = 3'd1,
		REG_Y_MIN       = 3'd2,
		REG_Y_MAX       = 3'd3,
		REG_Z_MIN       = 3'd4,
		REG_Z_MAX       = 3'd5,
		REG_AXIS_NEGATE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [15:0] ad;
		logic [16:0] quo;
		logic        neg;
		logic        ovf;
		logic        clr;
	} div_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               flip;
	} sc_t;

	typedef struct packed {
		div_t [2:0] dv;
		sc_t        roll;
		sc_t        pitch;
	} front_t;

	typedef struct packed {
		logic               zro;
		logic signed [AW-1:0] a;
		logic signed [AW-1:0] b;
		logic signed [ZW-1:0] z;
		logic signed [15:0] cal_x;
		logic signed [15:0] cal_y;
		logic signed [15:0] cal_z;
	} at_t;

	function automatic logic [29:0] atan_q30(input logic [SH_W-1:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/tcch_if.sv]
interface tcch_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface tcch_in_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] raw_mag_x;
	logic signed [15:0] raw_mag_y;
	logic signed [15:0] raw_mag_z;
	logic signed [15:0] roll_angle;
	logic signed [15:0] pitch_angle;
	modport source (output valid, output raw_mag_x, output raw_mag_y, output raw_mag_z,
		output roll_angle, output pitch_angle, input ready);
	modport sink (input valid, input raw_mag_x, input raw_mag_y, input raw_mag_z,
		input roll_angle, input pitch_angle, output ready);
endinterface

interface tcch_out_if;
	logic        valid;
	logic        ready;
	logic signed [15:0] cal_mag_x;
	logic signed [15:0] cal_mag_y;
	logic signed [15:0] cal_mag_z;
	logic signed [15:0] heading_angle;
	modport source (output valid, output cal_mag_x, output cal_mag_y, output cal_mag_z,
		output heading_angle, input ready);
	modport sink (input valid, input cal_mag_x, input cal_mag_y, input cal_mag_z,
		input heading_angle, output ready);
endinterface

[rtl/tcch_front_cell.sv]
module tcch_front_cell
	import tcch_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [SH_W-1:0] idx,
	input  logic            vld_d,
	input  front_t          d,
	output logic            vld_q,
	output front_t          data_q
);

	front_t nx;
	logic   div_on;
	logic   cor_on;

	function automatic div_t div_step(input div_t s, input logic [SH_W-1:0] i);
		logic [SH_W-1:0] sh;
		logic [32:0]     dsh;
		logic            ge;
		div_t            r;
		sh  = SH_W'(DIV_STEPS - 1) - i;
		dsh = {17'b0, s.ad} << sh;
		ge  = {2'b0, s.rem} >= dsh;
		r   = s;
		r.rem = ge ? 31'({2'b0, s.rem} - dsh) : s.rem;
		r.quo = {s.quo[15:0], ge};
		return r;
	endfunction

	function automatic sc_t sc_rot(input sc_t s, input logic [SH_W-1:0] i);
		logic signed [31:0] xs;
		logic signed [31:0] ys;
		logic signed [31:0] at;
		sc_t                r;
		xs = s.x >>> i;
		ys = s.y >>> i;
		at = $signed({2'b0, atan_q30(i)});
		r  = s;
		if (s.z >= 0) begin
			r.x = s.x - ys;
			r.y = s.y + xs;
			r.z = s.z - at;
		end else begin
			r.x = s.x + ys;
			r.y = s.y - xs;
			r.z = s.z + at;
		end
		return r;
	endfunction

	assign div_on = idx < SH_W'(DIV_STEPS);
	assign cor_on = idx < SH_W'(CORDIC_N);

	always_comb begin
		nx = d;
		if (div_on) begin
			for (int k = 0; k < 3; k++) begin
				nx.dv[k] = div_step(d.dv[k], idx);
			end
		end
		if (cor_on) begin
			nx.roll  = sc_rot(d.roll, idx);
			nx.pitch = sc_rot(d.pitch, idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nx;
		end
	end

endmodule

[rtl/tcch_atan_cell.sv]
module tcch_atan_cell
	import tcch_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [SH_W-1:0] idx,
	input  logic            vld_d,
	input  at_t             d,
	output logic            vld_q,
	output at_t             data_q
);

	at_t                  nx;
	logic signed [AW-1:0] as;
	logic signed [AW-1:0] bs;
	logic signed [ZW-1:0] at;

	assign as = d.a >>> idx;
	assign bs = d.b >>> idx;
	assign at = $signed({5'b0, atan_q30(idx)});

	always_comb begin
		nx = d;
		if (d.b >= 0) begin
			nx.a = d.a + bs;
			nx.b = d.b - as;
			nx.z = d.z + at;
		end else begin
			nx.a = d.a - bs;
			nx.b = d.b + as;
			nx.z = d.z - at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nx;
		end
	end

endmodule

[rtl/tilt_compensated_compass_heading_top.sv]
// Path: entry register, front cell row, product registers, back cell row, output register.
// Throughput: one request per cycle; the whole pipeline advances while the output is free.
// Front cells carry one divider bit per axis; the first CORDIC_N also carry one sine/cosine CORDIC step.
// The back cell row carries one atan2 CORDIC step per cell.
// Reset clears all valid bits and loads calibration defaults (-512 / 512, no negation).
module tilt_compensated_compass_heading_top
	import tcch_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tcch_cfg_if.sink cfg,
	tcch_in_if.sink  sample,
	tcch_out_if.source result
);

	logic signed [15:0] x_min_q, x_max_q, y_min_q, y_max_q, z_min_q, z_max_q;
	logic [2:0]         axis_negate_q;
	logic               adv;

	logic   vld_s1;
	front_t fr_s1;
	logic   fr_vld [FRONT_DEPTH+1];
	front_t fr_dat [FRONT_DEPTH+1];
	front_t fd;

	logic               vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [15:0] cx_s2, cy_s2, cz_s2, cx_s3, cy_s3, cz_s3;
	logic signed [15:0] cx_s4, cy_s4, cz_s4, cx_s5, cy_s5, cz_s5;
	logic signed [63:0] pyy_s2, pxy_s2;
	logic               sflip_s2, flipr_s2, flipp_s2;
	logic signed [31:0] xr_s2, yr_s2, xp_s2;
	logic signed [63:0] pyy_n, pxy_n;
	logic signed [31:0] srsp_s3, crsp_s3, sr_s3, cr_s3, cp_s3;
	logic signed [47:0] pxcp_s4, pysr_s4, pzcr_s4, pycr_s4, pzsr_s4;
	logic signed [AW-1:0] hx_s5, nhy_s5;
	at_t                at_pre;
	at_t                at_s6;
	logic               at_vld [CORDIC_N+1];
	at_t                at_dat [CORDIC_N+1];
	at_t                ad_l;

	logic signed [ZW-1:0] zr;
	logic signed [ZW-1:0] hr;
	logic signed [15:0]   hd;

	logic               out_vld_q;
	logic signed [15:0] out_x_q, out_y_q, out_z_q, out_h_q;

	function automatic div_t cal_pre(input logic signed [15:0] raw, input logic signed [15:0] mn,
		input logic signed [15:0] mx, input logic neg);
		logic signed [16:0] num;
		logic signed [16:0] den;
		logic signed [18:0] t;
		logic signed [31:0] n;
		div_t               r;
		num = neg ? 17'(raw) + 17'(mn) : 17'(raw) - 17'(mn);
		den = 17'(mx) - 17'(mn);
		t   = neg ? (19'(num) <<< 1) + 19'(den) : (19'(num) <<< 1) - 19'(den);
		n   = 32'(t) <<< 13;
		r.ad  = den[16] ? 16'(-den) : den[15:0];
		r.rem = n[31] ? 31'(-n) : n[30:0];
		r.quo = '0;
		if (den == 0) begin
			r.ovf = num != 0;
			r.neg = num[16];
			r.clr = num == 0;
		end else begin
			r.ovf = {2'b0, r.rem} >= {r.ad, 17'b0};
			r.neg = n[31] != den[16];
			r.clr = 1'b0;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] cal_fin(input div_t s);
		logic [17:0]        q;
		logic signed [15:0] r;
		q = 18'(s.quo) + 18'({s.rem, 1'b0} >= {16'b0, s.ad});
		if (s.clr) begin
			r = '0;
		end else if (s.neg) begin
			r = (s.ovf || q > 18'd32768) ? -16'sd32768 : $signed(16'(~q + 18'd1));
		end else begin
			r = (s.ovf || q > 18'd32767) ? 16'sd32767 : $signed(q[15:0]);
		end
		return r;
	endfunction

	function automatic sc_t sc_pre(input logic signed [15:0] a13);
		logic signed [33:0] z;
		sc_t                r;
		z = $signed({a13[15], a13, 17'b0});
		r.x = GAIN_Q30;
		r.y = '0;
		r.flip = 1'b0;
		if (z > HALF_PI_Q30) begin
			z = z - PI_Q30;
			r.flip = 1'b1;
		end else if (z < -HALF_PI_Q30) begin
			z = z + PI_Q30;
			r.flip = 1'b1;
		end
		r.z = 32'(z);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= -16'sd512;
			x_max_q <= 16'sd512;
			y_min_q <= -16'sd512;
			y_max_q <= 16'sd512;
			z_min_q <= -16'sd512;
			z_max_q <= 16'sd512;
			axis_negate_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (reg_idx_t'(cfg.index))
				REG_X_MIN:       x_min_q <= $signed(cfg.data);
				REG_X_MAX:       x_max_q <= $signed(cfg.data);
				REG_Y_MIN:       y_min_q <= $signed(cfg.data);
				REG_Y_MAX:       y_max_q <= $signed(cfg.data);
				REG_Z_MIN:       z_min_q <= $signed(cfg.data);
				REG_Z_MAX:       z_max_q <= $signed(cfg.data);
				REG_AXIS_NEGATE: axis_negate_q <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg.ready    = 1'b1;
	assign adv          = !out_vld_q || result.ready;
	assign sample.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= sample.valid;
			vld_s2    <= fr_vld[FRONT_DEPTH];
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_vld_q <= at_vld[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s1.dv[0] <= cal_pre(sample.raw_mag_x, x_min_q, x_max_q, axis_negate_q[0]);
			fr_s1.dv[1] <= cal_pre(sample.raw_mag_y, y_min_q, y_max_q, axis_negate_q[1]);
			fr_s1.dv[2] <= cal_pre(sample.raw_mag_z, z_min_q, z_max_q, axis_negate_q[2]);
			fr_s1.roll  <= sc_pre(sample.roll_angle);
			fr_s1.pitch <= sc_pre(sample.pitch_angle);
		end
	end

	assign fr_vld[0] = vld_s1;
	assign fr_dat[0] = fr_s1;

	for (genvar k = 0; k < FRONT_DEPTH; k++) begin : g_front
		tcch_front_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (SH_W'(k)),
			.vld_d  (fr_vld[k]),
			.d      (fr_dat[k]),
			.vld_q  (fr_vld[k+1]),
			.data_q (fr_dat[k+1])
		);
	end

	assign fd = fr_dat[FRONT_DEPTH];

	always_comb begin
		pyy_n = sflip_s2 ? -pyy_s2 : pyy_s2;
		pxy_n = sflip_s2 ? -pxy_s2 : pxy_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s2    <= cal_fin(fd.dv[0]);
			cy_s2    <= cal_fin(fd.dv[1]);
			cz_s2    <= cal_fin(fd.dv[2]);
			pyy_s2   <= $signed(fd.roll.y) * $signed(fd.pitch.y);
			pxy_s2   <= $signed(fd.roll.x) * $signed(fd.pitch.y);
			sflip_s2 <= fd.roll.flip ^ fd.pitch.flip;
			flipr_s2 <= fd.roll.flip;
			flipp_s2 <= fd.pitch.flip;
			xr_s2    <= fd.roll.x;
			yr_s2    <= fd.roll.y;
			xp_s2    <= fd.pitch.x;

			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			cz_s3   <= cz_s2;
			srsp_s3 <= 32'(pyy_n >>> 30);
			crsp_s3 <= 32'(pxy_n >>> 30);
			sr_s3   <= flipr_s2 ? -yr_s2 : yr_s2;
			cr_s3   <= flipr_s2 ? -xr_s2 : xr_s2;
			cp_s3   <= flipp_s2 ? -xp_s2 : xp_s2;

			cx_s4   <= cx_s3;
			cy_s4   <= cy_s3;
			cz_s4   <= cz_s3;
			pxcp_s4 <= cx_s3 * cp_s3;
			pysr_s4 <= cy_s3 * srsp_s3;
			pzcr_s4 <= cz_s3 * crsp_s3;
			pycr_s4 <= cy_s3 * cr_s3;
			pzsr_s4 <= cz_s3 * sr_s3;

			cx_s5  <= cx_s4;
			cy_s5  <= cy_s4;
			cz_s5  <= cz_s4;
			hx_s5  <= AW'(pxcp_s4) + AW'(pysr_s4) + AW'(pzcr_s4);
			nhy_s5 <= AW'(pzsr_s4) - AW'(pycr_s4);

			at_s6 <= at_pre;
		end
	end

	always_comb begin
		at_pre.zro   = (hx_s5 == 0) && (nhy_s5 == 0);
		at_pre.cal_x = cx_s5;
		at_pre.cal_y = cy_s5;
		at_pre.cal_z = cz_s5;
		if (hx_s5 < 0) begin
			at_pre.a = -hx_s5;
			at_pre.b = -nhy_s5;
			at_pre.z = (nhy_s5 >= 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
		end else begin
			at_pre.a = hx_s5;
			at_pre.b = nhy_s5;
			at_pre.z = '0;
		end
	end

	assign at_vld[0] = vld_s6;
	assign at_dat[0] = at_s6;

	for (genvar k = 0; k < CORDIC_N; k++) begin : g_atan
		tcch_atan_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.idx    (SH_W'(k)),
			.vld_d  (at_vld[k]),
			.d      (at_dat[k]),
			.vld_q  (at_vld[k+1]),
			.data_q (at_dat[k+1])
		);
	end

	assign ad_l = at_dat[CORDIC_N];
	assign zr   = ad_l.z + ZW'(65536);
	assign hr   = zr >>> 17;

	always_comb begin
		priority if (ad_l.zro) begin
			hd = '0;
		end else if (hr > ZW'(HEADING_LIMIT)) begin
			hd = HEADING_LIMIT;
		end else if (hr < -ZW'(HEADING_LIMIT)) begin
			hd = -HEADING_LIMIT;
		end else begin
			hd = hr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_x_q <= ad_l.cal_x;
			out_y_q <= ad_l.cal_y;
			out_z_q <= ad_l.cal_z;
			out_h_q <= hd;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.cal_mag_x     = out_x_q;
	assign result.cal_mag_y     = out_y_q;
	assign result.cal_mag_z     = out_z_q;
	assign result.heading_angle = out_h_q;

`ifndef NO_ASSERTIONS
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.heading_angle <= HEADING_LIMIT &&
			result.heading_angle >= -HEADING_LIMIT))
		else $error("heading out of range");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld_s1)
		else $error("accepted request lost at entry");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s6) && $stable(fr_vld[FRONT_DEPTH]))
		else $error("pipeline moved during stall");
`endif

endmodule

[tb/tcch_checker.sv]
`timescale 1ns / 100ps

module tcch_checker
	import tcch_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tcch_cfg_if.sink    cfg,
	tcch_in_if.sink     sample,
	tcch_out_if.sink    result,
	output int          errors,
	output int          pending
);

	typedef struct {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
		logic signed [15:0] hdg;
	} heading_t;

	localparam longint PI_RAD  = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint K_GAIN  = 64'sd652032874;
	localparam longint H_LIM   = 64'sd25736;

	localparam longint ARCTAN [24] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128};

	logic signed [15:0] lo [3];
	logic signed [15:0] hi [3];
	logic [2:0]         neg_mask;
	heading_t           heading_q [$];

	function automatic longint calibrate_axis(longint raw, longint mn, longint mx, bit neg);
		longint num, den, n, an, ad, q;
		num = neg ? raw + mn : raw - mn;
		den = mx - mn;
		if (den == 0)
			return (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
		n  = (2 * num + (neg ? den : -den)) * 8192;
		an = (n < 0) ? -n : n;
		ad = (den < 0) ? -den : den;
		q  = (2 * an + ad) / (2 * ad);
		if ((n < 0) != (den < 0))
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q;
	endfunction

	function automatic void tilt_sincos(input logic signed [15:0] ang, output longint s,
		output longint c);
		longint z, x, y, t;
		bit     flip;
		z    = longint'(ang) * 131072;
		x    = K_GAIN;
		y    = 0;
		flip = 0;
		if (z > HALF_PI) begin
			z    = z - PI_RAD;
			flip = 1;
		end else if (z < -HALF_PI) begin
			z    = z + PI_RAD;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			t = x;
			if (z >= 0) begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				z = z - ARCTAN[i];
			end else begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				z = z + ARCTAN[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint heading_q13(longint b, longint a);
		longint z, t, r;
		z = 0;
		if (a == 0 && b == 0)
			return 0;
		if (a < 0) begin
			z = (b >= 0) ? PI_RAD : -PI_RAD;
			a = -a;
			b = -b;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			t = a;
			if (b >= 0) begin
				a = a + (b >>> i);
				b = b - (t >>> i);
				z = z + ARCTAN[i];
			end else begin
				a = a - (b >>> i);
				b = b + (t >>> i);
				z = z - ARCTAN[i];
			end
		end
		r = (z + 65536) >>> 17;
		if (r > H_LIM)
			r = H_LIM;
		if (r < -H_LIM)
			r = -H_LIM;
		return r;
	endfunction

	function automatic heading_t predict_heading(logic signed [15:0] rx, logic signed [15:0] ry,
		logic signed [15:0] rz, logic signed [15:0] roll, logic signed [15:0] pitch);
		heading_t e;
		longint   cx, cy, cz, sr, cr, sp, cp, srsp, crsp, hx, hy;
		cx   = calibrate_axis(rx, lo[0], hi[0], neg_mask[0]);
		cy   = calibrate_axis(ry, lo[1], hi[1], neg_mask[1]);
		cz   = calibrate_axis(rz, lo[2], hi[2], neg_mask[2]);
		tilt_sincos(roll, sr, cr);
		tilt_sincos(pitch, sp, cp);
		srsp = (sr * sp) >>> 30;
		crsp = (cr * sp) >>> 30;
		hx   = cx * cp + cy * srsp + cz * crsp;
		hy   = cy * cr - cz * sr;
		e.cx  = cx[15:0];
		e.cy  = cy[15:0];
		e.cz  = cz[15:0];
		e.hdg = 16'(heading_q13(-hy, hx));
		return e;
	endfunction

	assign pending = heading_q.size();

	always @(posedge clk or negedge arst_n) begin
		heading_t e;
		if (!arst_n) begin
			lo       = '{-16'sd512, -16'sd512, -16'sd512};
			hi       = '{16'sd512, 16'sd512, 16'sd512};
			neg_mask = '0;
			errors   = 0;
			heading_q.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (heading_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = heading_q.pop_front();
					if (result.cal_mag_x !== e.cx) begin
						$error("cal_mag_x exp %0d got %0d", e.cx, result.cal_mag_x);
						errors++;
					end
					if (result.cal_mag_y !== e.cy) begin
						$error("cal_mag_y exp %0d got %0d", e.cy, result.cal_mag_y);
						errors++;
					end
					if (result.cal_mag_z !== e.cz) begin
						$error("cal_mag_z exp %0d got %0d", e.cz, result.cal_mag_z);
						errors++;
					end
					if (result.heading_angle !== e.hdg) begin
						$error("heading_angle exp %0d got %0d", e.hdg, result.heading_angle);
						errors++;
					end
				end
			end
			if (sample.valid && sample.ready)
				heading_q.push_back(predict_heading(sample.raw_mag_x, sample.raw_mag_y,
					sample.raw_mag_z, sample.roll_angle, sample.pitch_angle));
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_X_MIN:       lo[0] = cfg.data;
					REG_X_MAX:       hi[0] = cfg.data;
					REG_Y_MIN:       lo[1] = cfg.data;
					REG_Y_MAX:       hi[1] = cfg.data;
					REG_Z_MIN:       lo[2] = cfg.data;
					REG_Z_MAX:       hi[2] = cfg.data;
					REG_AXIS_NEGATE: neg_mask = cfg.data[2:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import tcch_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 250;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   requests;
	int   settings;
	bit   burst;
	int   hold;

	tcch_cfg_if cfg ();
	tcch_in_if  sample ();
	tcch_out_if result ();

	tilt_compensated_compass_heading_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.result (result)
	);

	tcch_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.sample  (sample),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold         <= 0;
		end else if (hold > 0) begin
			hold <= hold - 1;
		end else if (burst) begin
			result.ready <= 1'b1;
		end else begin
			result.ready <= ($urandom_range(0, 2) != 0);
			hold         <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic load_cal(logic [15:0] v [7]);
		cfg.valid <= 1'b1;
		for (int i = 0; i < 7; i++) begin
			cfg.index <= 3'(i);
			cfg.data  <= v[i];
			do @(posedge clk); while (!cfg.ready);
		end
		cfg.valid <= 1'b0;
		settings++;
	endtask

	task automatic send_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
		logic [15:0] roll, logic [15:0] pitch);
		int g;
		g = pick_gap();
		if (g > 0) begin
			sample.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		sample.valid       <= 1'b1;
		sample.raw_mag_x   <= rx;
		sample.raw_mag_y   <= ry;
		sample.raw_mag_z   <= rz;
		sample.roll_angle  <= roll;
		sample.pitch_angle <= pitch;
		do @(posedge clk); while (!sample.ready);
		requests++;
	endtask

	function automatic logic [15:0] rand_raw();
		if ($urandom_range(0, 9) < 4)
			return 16'($urandom);
		return 16'($urandom_range(0, 2047) - 1024);
	endfunction

	function automatic logic [15:0] rand_angle();
		if ($urandom_range(0, 9) < 3)
			return 16'($urandom);
		return 16'($urandom_range(0, 51472) - 25736);
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				burst <= ($urandom_range(0, 3) == 0);
			send_sample(rand_raw(), rand_raw(), rand_raw(), rand_angle(), rand_angle());
		end
		sample.valid <= 1'b0;
		burst        <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] cal [7];
		requests     = 0;
		settings     = 0;
		burst        = 0;
		arst_n       = 1'b0;
		cfg.valid    = 1'b0;
		cfg.index    = '0;
		cfg.data     = '0;
		sample.valid = 1'b0;
		sample.raw_mag_x   = '0;
		sample.raw_mag_y   = '0;
		sample.raw_mag_z   = '0;
		sample.roll_angle  = '0;
		sample.pitch_angle = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h0000, 16'sd25736, -16'sd25736);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		send_sample(16'sd512, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(-16'sd512, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'sd300, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h0000, -16'sd300, 16'h0000, 16'h0000, 16'h0000);
		send_sample(-16'sd200, 16'sd1, 16'h0000, 16'h0000, 16'h0000);
		send_sample(-16'sd200, -16'sd1, 16'h0000, 16'h0000, 16'h0000);
		send_sample(16'sd100, 16'sd100, 16'sd100, 16'sd25736, 16'sd25736);
		send_sample(16'sd100, -16'sd50, 16'sd70, -16'sd25736, -16'sd25736);
		send_sample(16'sd100, 16'sd40, -16'sd90, 16'sd12868, 16'sd12868);
		send_sample(16'sd100, 16'sd40, -16'sd90, -16'sd12868, 16'sd12869);
		send_sample(16'sd100, 16'sd40, -16'sd90, 16'sd12869, -16'sd12869);
		send_sample(16'sd250, -16'sd60, 16'sd30, 16'h7fff, 16'h8000);
		send_sample(-16'sd250, 16'sd60, 16'sd30, 16'h8000, 16'h7fff);
		send_sample(16'sd5, 16'sd400, 16'sd400, 16'sd4000, -16'sd6000);
		send_sample(16'h5555, 16'haaaa, 16'h5555, 16'h2aaa, 16'hd555);
		send_sample(16'haaaa, 16'h5555, 16'haaaa, 16'hd555, 16'h2aaa);
		random_run(PHASE_ITEMS);

		cal = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0007};
		load_cal(cal);
		random_run(PHASE_ITEMS);

		cal = '{16'sd100, 16'sd100, 16'sd500, -16'sd500, 16'sd0, 16'sd1, 16'h0005};
		load_cal(cal);
		send_sample(16'sd100, 16'sd0, 16'sd0, 16'h0000, 16'h0000);
		send_sample(16'sd101, 16'sd0, 16'sd1, 16'h0000, 16'h0000);
		send_sample(16'sd99, 16'sd0, 16'sd2, 16'h0000, 16'h0000);
		send_sample(-16'sd100, 16'sd0, 16'sd0, 16'h0000, 16'h0000);
		random_run(PHASE_ITEMS);

		cal = '{16'h7fff, 16'h8000, 16'h8000, 16'h8000, -16'sd300, 16'sd700, 16'h0002};
		load_cal(cal);
		send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000);
		send_sample(16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
		random_run(PHASE_ITEMS);

		for (int p = 0; p < 3; p++) begin
			for (int i = 0; i < 6; i++)
				cal[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom)
					: 16'($urandom_range(0, 1200) - 600);
			cal[6] = 16'($urandom);
			load_cal(cal);
			random_run(PHASE_ITEMS);
		end

		cal = '{-16'sd512, 16'sd512, -16'sd512, 16'sd512, -16'sd512, 16'sd512, 16'h0000};
		load_cal(cal);
		random_run(50);

		repeat (50) @(posedge clk);
		$display("Covered %0d samples over %0d calibration settings plus reset defaults,",
			requests, settings);
		$display("with random gaps and output stalls; %0d mismatches.", errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[tilt_compensated_compass_heading_top.f]
rtl/tcch_pkg.sv
rtl/tcch_if.sv
rtl/tcch_front_cell.sv
rtl/tcch_atan_cell.sv
rtl/tilt_compensated_compass_heading_top.sv
tb/tcch_checker.sv
tb/testbench.sv
